// ===== src/wdm_pkg.sv =====
// Package for the wavetable synthesizer: sizes, command codes, register
// indexes and the write-port struct that runs between the top level and the wave RAM.
// No dependencies.
`default_nettype none

package wdm_pkg;

   // Wave table geometry
   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);

   // Phase accumulator format (10.16 in 26 bits)
   localparam int PHASE_W   = 26;
   localparam int FRAC_BITS = 16;
   localparam int INT_W     = PHASE_W - FRAC_BITS;

   // Mixer arithmetic
   localparam int SAMPLE_W   = 16;
   localparam int SUM_W      = SAMPLE_W + 2;
   localparam int PROD_W     = SUM_W + 13;
   localparam int GAIN_SHIFT = 17;
   localparam int SHIFT_W    = PROD_W - GAIN_SHIFT;
   localparam int Y_W        = SHIFT_W + 1;
   localparam int DUTY_W     = 12;
   localparam logic [DUTY_W-1:0] DUTY_MAX = 12'd4095;

   // Result buffer slots (bounds the number of ticks in flight)
   localparam int OUT_SLOTS = 4;
   localparam int SLOT_W    = $clog2(OUT_SLOTS);

   // Commands
   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   // Register indexes
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 26;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_A       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_B       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_C       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_D       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_VOLUME       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_TABLE_LENGTH = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_BIAS         = 3'd6;

   // Register reset values
   localparam logic [11:0] VOLUME_RESET = 12'd2048;
   localparam logic [10:0] LENGTH_RESET = 11'd1000;
   localparam logic [11:0] BIAS_RESET   = 12'd1200;

   // Wave RAM write port
   typedef struct packed {
      logic                en;
      logic [IDX_W-1:0]    addr;
      logic [SAMPLE_W-1:0] data;
   } wdm_ram_wr_type;

endpackage

`default_nettype wire

// ===== src/wdm_if.sv =====
// Handshake interfaces for the command channel and the duty channel.
// Depends on wdm_pkg for field widths.
`default_nettype none

interface wdm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [9:0]  table_index;
   logic signed [15:0] table_value;
   logic [1:0]  channel;

   modport source (output valid, command, table_index, table_value, channel, input ready);
   modport sink   (input valid, command, table_index, table_value, channel, output ready);
endinterface

interface wdm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [wdm_pkg::DUTY_W-1:0]    duty;

   modport source (output valid, duty, input ready);
   modport sink   (input valid, duty, output ready);
endinterface

`default_nettype wire

// ===== src/wdm_wave_ram.sv =====
// Wave table storage: one write port, one read port, registered read data.
// Depends on wdm_pkg for depth, widths and the write port struct.
`default_nettype none

module wdm_wave_ram (
   input  wire logic                            clock,
   input  wire wdm_pkg::wdm_ram_wr_type         wr,
   input  wire logic [wdm_pkg::IDX_W-1:0]       rd_addr,
   output logic [wdm_pkg::SAMPLE_W-1:0]         rd_data
);

   logic [wdm_pkg::SAMPLE_W-1:0] mem [wdm_pkg::TABLE_DEPTH];

   // write and read share the edge; a read of the written address returns old data
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== src/wavetable_dds_mixer.sv =====
// Four-channel wavetable synthesizer with clamped PWM duty output.
// Depends on wdm_pkg, wdm_if (wdm_req_if, wdm_rsp_if) and wdm_wave_ram.
//
//  channel   direction  handshake            payload
//  req_ch    in         valid/ready          command, table_index, table_value, channel
//  rsp_ch    out        valid/ready          duty (one word per tick)
//  csr_*     in         csr_we, no wait      csr_index, csr_wdata
//
// A tick reads the four channels in turn: the single wave RAM read port serves one
// channel per cycle. A duty word passes through the RAM read data, the sum register,
// the product register and the result buffer. Up to four ticks may be owed; with four in
// flight or waiting in the result buffer, req_ch is held off until rsp_ch takes one.
// Reset is synchronous; the wave table is not cleared and must be loaded.

`default_nettype none

module wavetable_dds_mixer (
   input  wire logic                              clock,
   input  wire logic                              reset,
   wdm_req_if.sink                                req_ch,
   wdm_rsp_if.source                              rsp_ch,
   input  wire logic                              csr_we,
   input  wire logic [wdm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [wdm_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int PW = wdm_pkg::PHASE_W;

   // configuration registers
   logic [PW-1:0] step_ff [4];
   logic [11:0]   volume_ff;
   logic [10:0]   length_ff;
   logic [11:0]   bias_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff[0] <= '0;
         step_ff[1] <= '0;
         step_ff[2] <= '0;
         step_ff[3] <= '0;
         volume_ff  <= wdm_pkg::VOLUME_RESET;
         length_ff  <= wdm_pkg::LENGTH_RESET;
         bias_ff    <= wdm_pkg::BIAS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            wdm_pkg::REG_STEP_A:       step_ff[0] <= csr_wdata[PW-1:0];
            wdm_pkg::REG_STEP_B:       step_ff[1] <= csr_wdata[PW-1:0];
            wdm_pkg::REG_STEP_C:       step_ff[2] <= csr_wdata[PW-1:0];
            wdm_pkg::REG_STEP_D:       step_ff[3] <= csr_wdata[PW-1:0];
            wdm_pkg::REG_VOLUME:       volume_ff  <= csr_wdata[11:0];
            wdm_pkg::REG_TABLE_LENGTH: length_ff  <= csr_wdata[10:0];
            wdm_pkg::REG_BIAS:         bias_ff    <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   // control state
   logic                          busy_ff, busy_in;
   logic [1:0]                    cnt_ff, cnt_in;
   logic [2:0]                    owed_ff, owed_in;
   logic [PW-1:0]                 phase_ff [4];
   logic [PW-1:0]                 phase_in [4];

   logic req_take, take_tick, take_write, take_clear, rsp_take;

   // a new word enters on the last sequencer cycle or when idle, while fewer than four ticks are owed
   assign req_ch.ready = (!busy_ff || cnt_ff == 2'd3) && owed_ff != 3'(wdm_pkg::OUT_SLOTS);
   assign req_take     = req_ch.valid && req_ch.ready;
   assign take_tick    = req_take && req_ch.command == wdm_pkg::CMD_TICK;
   assign take_write   = req_take && req_ch.command == wdm_pkg::CMD_WRITE;
   assign take_clear   = req_take && req_ch.command == wdm_pkg::CMD_CLEAR;
   assign rsp_take     = rsp_ch.valid && rsp_ch.ready;

   // phase advance for the channel in turn
   logic [PW:0]   sum_ph;
   logic [PW:0]   adv_full;
   logic [PW-1:0] adv_phase;
   logic [wdm_pkg::INT_W-1:0] rd_int;
   logic          rd_in_range;

   always_comb begin
      sum_ph = {1'b0, phase_ff[cnt_ff]} + {1'b0, step_ff[cnt_ff]};
      if (sum_ph[PW:wdm_pkg::FRAC_BITS] >= length_ff) begin
         adv_full = sum_ph - {length_ff, {wdm_pkg::FRAC_BITS{1'b0}}};
      end else begin
         adv_full = sum_ph;
      end
      adv_phase   = adv_full[PW-1:0];
      rd_int      = adv_phase[PW-1:wdm_pkg::FRAC_BITS];
      rd_in_range = 32'(rd_int) < wdm_pkg::TABLE_DEPTH;
   end

   // sequencer, phase store and outstanding-tick count
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      for (int k = 0; k < 4; k++) begin
         phase_in[k] = phase_ff[k];
      end
      if (busy_ff) begin
         phase_in[cnt_ff] = adv_phase;
         cnt_in = cnt_ff + 2'd1;
         if (cnt_ff == 2'd3) begin
            busy_in = 1'b0;
         end
      end
      if (take_tick) begin
         busy_in = 1'b1;
         cnt_in  = 2'd0;
      end
      // a clear comes after the tick in flight
      if (take_clear) begin
         phase_in[req_ch.channel] = '0;
      end
      owed_in = owed_ff + 3'(take_tick) - 3'(rsp_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         owed_ff <= '0;
         for (int k = 0; k < 4; k++) begin
            phase_ff[k] <= '0;
         end
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         owed_ff <= owed_in;
         for (int k = 0; k < 4; k++) begin
            phase_ff[k] <= phase_in[k];
         end
      end
   end

   // wave RAM
   wdm_pkg::wdm_ram_wr_type      ram_wr;
   logic [wdm_pkg::SAMPLE_W-1:0] ram_q;

   always_comb begin
      ram_wr.en   = take_write && 32'(req_ch.table_index) < wdm_pkg::TABLE_DEPTH;
      ram_wr.addr = wdm_pkg::IDX_W'(req_ch.table_index);
      ram_wr.data = req_ch.table_value;
   end

   wdm_wave_ram u_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd_addr (wdm_pkg::IDX_W'(rd_int)),
      .rd_data (ram_q)
   );

   // read tags, aligned with RAM data
   logic rd_vld_ff, rd_first_ff, rd_last_ff, rd_zero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= busy_ff;
      end
      rd_first_ff <= cnt_ff == 2'd0;
      rd_last_ff  <= cnt_ff == 2'd3;
      rd_zero_ff  <= !rd_in_range;
   end

   // accumulate four entries
   logic signed [wdm_pkg::SUM_W-1:0] acc_ff, acc_in, term, sum_ff;
   logic sum_vld_ff;

   always_comb begin
      term   = rd_zero_ff ? '0 : wdm_pkg::SUM_W'($signed(ram_q));
      acc_in = (rd_first_ff ? '0 : acc_ff) + term;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_vld_ff <= 1'b0;
      end else begin
         sum_vld_ff <= rd_vld_ff && rd_last_ff;
      end
      if (rd_vld_ff) begin
         acc_ff <= acc_in;
      end
      if (rd_vld_ff && rd_last_ff) begin
         sum_ff <= acc_in;
      end
   end

   // gain stage
   logic signed [wdm_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic prod_vld_ff;

   assign prod_in = wdm_pkg::PROD_W'(sum_ff) * wdm_pkg::PROD_W'($signed({1'b0, volume_ff}));

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= sum_vld_ff;
      end
      if (sum_vld_ff) begin
         prod_ff <= prod_in;
      end
   end

   // floor shift, bias and clamp
   logic signed [wdm_pkg::SHIFT_W-1:0] shifted;
   logic signed [wdm_pkg::Y_W-1:0]     y;
   logic [wdm_pkg::DUTY_W-1:0]         duty_in;

   always_comb begin
      shifted = wdm_pkg::SHIFT_W'(prod_ff >>> wdm_pkg::GAIN_SHIFT);
      y = wdm_pkg::Y_W'(shifted) + wdm_pkg::Y_W'($signed({1'b0, bias_ff}));
      if (y[wdm_pkg::Y_W-1]) begin
         duty_in = '0;
      end else if (y > wdm_pkg::Y_W'($signed({1'b0, wdm_pkg::DUTY_MAX}))) begin
         duty_in = wdm_pkg::DUTY_MAX;
      end else begin
         duty_in = y[wdm_pkg::DUTY_W-1:0];
      end
   end

   // result buffer; the owed count keeps it from overflowing
   logic [wdm_pkg::DUTY_W-1:0] buf_ff [wdm_pkg::OUT_SLOTS];
   logic [wdm_pkg::SLOT_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [wdm_pkg::SLOT_W:0]   fill_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (prod_vld_ff) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (rsp_take) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         fill_ff <= fill_ff + (wdm_pkg::SLOT_W+1)'(prod_vld_ff)
                            - (wdm_pkg::SLOT_W+1)'(rsp_take);
      end
      if (prod_vld_ff) begin
         buf_ff[wr_ptr_ff] <= duty_in;
      end
   end

   assign rsp_ch.valid = fill_ff != '0;
   assign rsp_ch.duty  = buf_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// ===== test/wdm_checker.sv =====
// Checker for the wavetable synthesizer: watches the command, duty and register ports,
// predicts each duty word, and compares the words the block delivers, in order.
// Depends on wdm_pkg and on wdm_if (wdm_req_if, wdm_rsp_if).
`default_nettype none

module wdm_checker
   import wdm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   wdm_req_if                         req_mon,
   wdm_rsp_if                         rsp_mon,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output int                         mismatches,
   output int                         outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   // Shadow of the block's registers and state
   logic [PHASE_W-1:0]         inc_reg   [4];
   logic [PHASE_W-1:0]         phase_acc [4];
   logic [11:0]                gain_reg;
   logic [10:0]                period_reg;
   logic [11:0]                offset_reg;
   logic signed [SAMPLE_W-1:0] wave_mem  [TABLE_DEPTH];

   // Duty words still owed by the block, oldest first
   logic [DUTY_W-1:0] duty_expect [$];

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   // One accumulator update: add, then at most one wrap by the period
   function automatic logic [PHASE_W-1:0] next_phase(input logic [PHASE_W-1:0] ph,
                                                    input logic [PHASE_W-1:0] inc,
                                                    input logic [10:0]        period);
      logic [PHASE_W:0] acc;
      acc = {1'b0, ph} + {1'b0, inc};
      if (acc[PHASE_W:FRAC_BITS] >= period)
         acc = acc - {period, {FRAC_BITS{1'b0}}};
      return acc[PHASE_W-1:0];
   endfunction

   // Sum of the four looked-up samples, scaled, biased and clamped
   function automatic logic [DUTY_W-1:0] mixed_duty();
      longint sum;
      longint level;
      sum = 0;
      for (int k = 0; k < 4; k++)
         sum += longint'(wave_mem[phase_acc[k][PHASE_W-1:FRAC_BITS]]);
      // arithmetic shift of a signed value floors toward minus infinity
      level = ((sum * longint'({1'b0, gain_reg})) >>> GAIN_SHIFT)
              + longint'({1'b0, offset_reg});
      if (level > longint'(DUTY_MAX))
         level = longint'(DUTY_MAX);
      if (level < 0)
         level = 0;
      return level[DUTY_W-1:0];
   endfunction

   always @(posedge clock) begin : track
      logic [DUTY_W-1:0] want;
      if (reset) begin
         for (int k = 0; k < 4; k++) begin
            inc_reg[k]   = '0;
            phase_acc[k] = '0;
         end
         gain_reg   = VOLUME_RESET;
         period_reg = LENGTH_RESET;
         offset_reg = BIAS_RESET;
         duty_expect.delete();
      end else begin
         // register writes
         if (csr_we) begin
            case (csr_index)
               REG_STEP_A:       inc_reg[0] = csr_wdata[PHASE_W-1:0];
               REG_STEP_B:       inc_reg[1] = csr_wdata[PHASE_W-1:0];
               REG_STEP_C:       inc_reg[2] = csr_wdata[PHASE_W-1:0];
               REG_STEP_D:       inc_reg[3] = csr_wdata[PHASE_W-1:0];
               REG_VOLUME:       gain_reg   = csr_wdata[11:0];
               REG_TABLE_LENGTH: period_reg = csr_wdata[10:0];
               REG_BIAS:         offset_reg = csr_wdata[11:0];
               default: ;
            endcase
         end

         // accepted command word
         if (req_mon.valid && req_mon.ready) begin
            case (req_mon.command)
               CMD_TICK: begin
                  for (int k = 0; k < 4; k++)
                     phase_acc[k] = next_phase(phase_acc[k], inc_reg[k], period_reg);
                  duty_expect.push_back(mixed_duty());
               end
               CMD_WRITE: wave_mem[req_mon.table_index] = req_mon.table_value;
               CMD_CLEAR: phase_acc[req_mon.channel] = '0;
               default: ;  // unused code, no effect
            endcase
         end

         // accepted duty word
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (duty_expect.size() == 0) begin
               $error("duty: expected none, actual %0d", rsp_mon.duty);
               mismatches++;
            end else begin
               want = duty_expect.pop_front();
               if (rsp_mon.duty !== want) begin
                  $error("duty: expected %0d, actual %0d", want, rsp_mon.duty);
                  mismatches++;
               end
            end
         end
      end
      outstanding <= duty_expect.size();
   end

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Top of the wavetable synthesizer testbench: clock, reset, command and register
// stimulus, duty backpressure and the verdict. Depends on wdm_pkg, wdm_if,
// wavetable_dds_mixer and wdm_checker.
`default_nettype none

module tb;
   import wdm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_PAD   = 24;   // covers the tick pipeline and any write in flight
   localparam logic [1:0] CMD_SPARE = 2'd3;   // unused command code

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    mismatches;
   int                    outstanding;
   int                    cycle_count = 0;
   bit                    steady = 1'b0;   // no idling on either side while set

   wdm_req_if req_ch ();
   wdm_rsp_if rsp_ch ();

   wavetable_dds_mixer dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   wdm_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic int pick_gap();
      return steady ? 0 : int'($urandom_range(0, 12));
   endfunction

   // Duty side: idle a random number of cycles, then take one word
   initial begin : duty_sink
      int gap;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         gap = pick_gap();
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
      end
   end

   // One command word; valid stays high into the next word when there is no gap
   task automatic send_word(input logic [1:0] cmd, input logic [9:0] idx,
                            input logic signed [15:0] value, input logic [1:0] chan);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.command     <= cmd;
      req_ch.table_index <= idx;
      req_ch.table_value <= value;
      req_ch.channel     <= chan;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic send_tick();
      send_word(CMD_TICK, 10'($urandom), 16'($urandom), 2'($urandom));
   endtask

   // Hold the sender until every duty word is in and the block has gone quiet
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_PAD) @(posedge clock);
   endtask

   task automatic put_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic program_regs(input logic [CSR_DATA_W-1:0] inc_a, inc_b, inc_c, inc_d,
                               input logic [CSR_DATA_W-1:0] gain, period, offset);
      settle();
      put_reg(REG_STEP_A, inc_a);
      put_reg(REG_STEP_B, inc_b);
      put_reg(REG_STEP_C, inc_c);
      put_reg(REG_STEP_D, inc_d);
      put_reg(REG_VOLUME, gain);
      put_reg(REG_TABLE_LENGTH, period);
      put_reg(REG_BIAS, offset);
      csr_we <= 1'b0;
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_extreme_12();
      case ($urandom_range(0, 5))
         0:       return 0;
         1:       return 4095;
         default: return CSR_DATA_W'($urandom_range(0, 4095));
      endcase
   endfunction

   // One register setting followed by a burst of mostly ticks
   task automatic random_phase(input int count);
      int                    period;
      int                    roll;
      logic [CSR_DATA_W-1:0] inc [4];
      case ($urandom_range(0, 9))
         0:       period = 1;
         1:       period = TABLE_DEPTH;
         2:       period = 16;
         default: period = $urandom_range(1, TABLE_DEPTH);
      endcase
      for (int k = 0; k < 4; k++) begin
         case ($urandom_range(0, 9))
            0:       inc[k] = '0;
            1:       inc[k] = CSR_DATA_W'($urandom);           // may exceed one period
            2:       inc[k] = CSR_DATA_W'(period * 65536 - 1); // largest in-range step
            default: inc[k] = CSR_DATA_W'($urandom_range(0, period * 65536 - 1));
         endcase
      end
      program_regs(inc[0], inc[1], inc[2], inc[3], pick_extreme_12(),
                   CSR_DATA_W'(period), pick_extreme_12());
      steady = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 70)
            send_tick();
         else if (roll < 85)
            send_word(CMD_WRITE, 10'($urandom), 16'($urandom), 2'($urandom));
         else if (roll < 95)
            send_word(CMD_CLEAR, 10'($urandom), 16'($urandom), 2'($urandom));
         else
            send_word(CMD_SPARE, 10'($urandom), 16'($urandom), 2'($urandom));
         if ($urandom_range(0, 59) == 0)
            settle();
      end
   endtask

   initial begin : stimulus
      req_ch.valid       <= 1'b0;
      req_ch.command     <= CMD_TICK;
      req_ch.table_index <= '0;
      req_ch.table_value <= '0;
      req_ch.channel     <= '0;
      csr_we             <= 1'b0;
      csr_index          <= REG_STEP_A;
      csr_wdata          <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Load every table entry before any tick can read it
      for (int i = 0; i < TABLE_DEPTH; i++)
         send_word(CMD_WRITE, 10'(i), 16'($urandom), 2'($urandom));

      // Tick with the register reset values
      send_tick();

      // Full gain, high bias, all channels on entry 0: clamp at the top
      program_regs(0, 0, 0, 0, 4095, CSR_DATA_W'(TABLE_DEPTH), 4095);
      send_word(CMD_WRITE, 10'd0, 16'sh7fff, 2'd0);
      for (int k = 0; k < 4; k++)
         send_word(CMD_CLEAR, 10'($urandom), 16'($urandom), 2'(k));
      send_tick();
      send_word(CMD_WRITE, 10'd0, -16'sd32768, 2'd3);
      send_tick();
      send_word(CMD_SPARE, 10'h3ff, 16'shffff, 2'd3);   // unused command
      send_tick();

      // Zero bias: negative sum clamps at the bottom, then top entry written
      program_regs(0, 0, 0, 0, 4095, CSR_DATA_W'(TABLE_DEPTH), 0);
      send_tick();
      send_word(CMD_WRITE, 10'd1023, 16'sh7fff, 2'd1);
      send_word(CMD_WRITE, 10'd0, 16'sh7fff, 2'd2);
      send_tick();

      // Small negative sum floors toward minus infinity
      program_regs(0, 0, 0, 0, 1, 1000, 1200);
      send_word(CMD_WRITE, 10'd0, -16'sd1, 2'd0);
      send_tick();

      // Zero table length and oversized steps
      program_regs(26'h3ffffff, 26'(1000 * 65536), 26'h2000000, 26'd12345, 2048, 0, 1200);
      repeat (3) send_tick();

      // Length one with the largest steps
      program_regs(26'h3ffffff, 26'h3ffffff, 26'd1, 26'hffff, 2048, 1, 2048);
      repeat (2) send_tick();

      // Long period, then shrink it so phases sit beyond the new length
      program_regs(26'(1023 * 65536), 26'(700 * 65536), 26'(512 * 65536), 26'(3 * 65536),
                   3000, CSR_DATA_W'(TABLE_DEPTH), 100);
      send_tick();
      program_regs(26'(1023 * 65536), 26'(700 * 65536), 26'(512 * 65536), 26'(3 * 65536),
                   3000, 16, 100);
      repeat (2) send_tick();

      // Random settings and traffic
      for (int p = 0; p < 12; p++)
         random_phase(75);

      // Drain and verdict
      steady = 1'b0;
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_PAD) @(posedge clock);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
